FILE: design/bffa_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and the microcode ROM of the first-fit bitmap allocator.
// No dependencies; the sequencer, datapath and top level refer to this package by scoped names.
package bffa_pkg;

    localparam int unsigned DEF_MAX_ENTRIES = 1024;
    localparam int unsigned WORD_W          = 32;
    localparam int unsigned WORD_SH         = 5;
    localparam int unsigned FIRST_W         = 10;
    localparam int unsigned TOTAL_W         = 11;
    localparam int unsigned CNT_W           = 11;
    localparam int unsigned IDX_W           = 10;
    localparam int unsigned STAT_W          = 2;
    localparam int unsigned POP_W           = 6;
    localparam int unsigned APB_AW          = 3;
    localparam int unsigned APB_DW          = 32;
    localparam int unsigned REG_SEL_BIT     = 2;
    localparam int unsigned STEP_W          = 5;

    localparam logic [FIRST_W-1:0] FIRST_RST = FIRST_W'(10);
    localparam logic [TOTAL_W-1:0] TOTAL_RST = TOTAL_W'(1024);

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    localparam logic REG_FIRST = 1'b0;
    localparam logic REG_TOTAL = 1'b1;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef enum logic [STEP_W-1:0] {
        S_CLR    = 5'd0,
        S_IDLE   = 5'd1,
        S_POLL   = 5'd2,
        S_OPSEL  = 5'd3,
        S_FR0    = 5'd4,
        S_FR_BAD = 5'd5,
        S_FR1    = 5'd6,
        S_FR2    = 5'd7,
        S_AL0    = 5'd8,
        S_AL1    = 5'd9,
        S_AL2    = 5'd10,
        S_AL3    = 5'd11,
        S_FULL   = 5'd12,
        S_EMIT   = 5'd13,
        S_RC0    = 5'd14,
        S_RC1    = 5'd15,
        S_RC2    = 5'd16,
        S_RC3    = 5'd17
    } t_step;

    typedef enum logic [3:0] {
        C_ALWAYS      = 4'd0,
        C_PEND        = 4'd1,
        C_GO          = 4'd2,
        C_OP_FREE     = 4'd3,
        C_IDX_BAD     = 4'd4,
        C_RANGE_EMPTY = 4'd5,
        C_CLR_LAST    = 4'd6,
        C_SCAN_DONE   = 4'd7,
        C_HIT         = 4'd8,
        C_CHK_LAST    = 4'd9,
        C_OUT_ROOM    = 4'd10
    } t_cond;

    typedef enum logic [3:0] {
        D_NOP       = 4'd0,
        D_CLR       = 4'd1,
        D_TAKE      = 4'd2,
        D_LOAD_IDX  = 4'd3,
        D_SET_RANGE = 4'd4,
        D_FR_WRITE  = 4'd5,
        D_AL_INIT   = 4'd6,
        D_ADV       = 4'd7,
        D_SCAN      = 4'd8,
        D_SET_FULL  = 4'd9,
        D_EMIT      = 4'd10,
        D_RC_INIT   = 4'd11,
        D_RC_ACC    = 4'd12,
        D_RC_STORE  = 4'd13
    } t_dop;

    typedef struct packed {
        t_dop  dop;
        t_cond cond;
        t_step jmp_t;
        t_step jmp_f;
    } t_uword;

    typedef struct packed {
        t_dop dop;
        logic fire;
    } t_ctrl;

    typedef struct packed {
        logic op_free;
        logic idx_bad;
        logic range_empty;
        logic clr_last;
        logic scan_done;
        logic hit;
        logic chk_last;
        logic out_room;
    } t_dp_stat;

    typedef struct packed {
        logic     pend;
        logic     go;
        t_dp_stat stat;
    } t_flags;

    // Microcode ROM: one control word per step.
    function automatic t_uword ucode(input t_step s);
        t_uword w;
        case (s)
            S_CLR:    w = '{D_CLR,       C_CLR_LAST,    S_IDLE,   S_CLR};
            S_IDLE:   w = '{D_NOP,       C_PEND,        S_RC0,    S_POLL};
            S_POLL:   w = '{D_TAKE,      C_GO,          S_OPSEL,  S_IDLE};
            S_OPSEL:  w = '{D_NOP,       C_OP_FREE,     S_FR0,    S_AL0};
            S_FR0:    w = '{D_LOAD_IDX,  C_IDX_BAD,     S_FR_BAD, S_FR1};
            S_FR_BAD: w = '{D_SET_RANGE, C_ALWAYS,      S_EMIT,   S_EMIT};
            S_FR1:    w = '{D_NOP,       C_ALWAYS,      S_FR2,    S_FR2};
            S_FR2:    w = '{D_FR_WRITE,  C_ALWAYS,      S_EMIT,   S_EMIT};
            S_AL0:    w = '{D_AL_INIT,   C_RANGE_EMPTY, S_FULL,   S_AL1};
            S_AL1:    w = '{D_ADV,       C_ALWAYS,      S_AL2,    S_AL2};
            S_AL2:    w = '{D_SCAN,      C_SCAN_DONE,   S_AL3,    S_AL2};
            S_AL3:    w = '{D_NOP,       C_HIT,         S_EMIT,   S_FULL};
            S_FULL:   w = '{D_SET_FULL,  C_ALWAYS,      S_EMIT,   S_EMIT};
            S_EMIT:   w = '{D_EMIT,      C_OUT_ROOM,    S_IDLE,   S_EMIT};
            S_RC0:    w = '{D_RC_INIT,   C_RANGE_EMPTY, S_RC3,    S_RC1};
            S_RC1:    w = '{D_ADV,       C_ALWAYS,      S_RC2,    S_RC2};
            S_RC2:    w = '{D_RC_ACC,    C_CHK_LAST,    S_RC3,    S_RC2};
            S_RC3:    w = '{D_RC_STORE,  C_ALWAYS,      S_IDLE,   S_IDLE};
            default:  w = '{D_NOP,       C_ALWAYS,      S_IDLE,   S_IDLE};
        endcase
        return w;
    endfunction

endpackage

FILE: design/bffa_ram.sv
`timescale 1ns / 1ps
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module bffa_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

FILE: design/bffa_seq.sv
`timescale 1ns / 1ps
// Microcode sequencer: step counter, ROM lookup and conditional jump.
// Depends on bffa_pkg for the ROM, step codes and control structs.
module bffa_seq (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  bffa_pkg::t_flags i_flags,
    output bffa_pkg::t_ctrl  o_ctrl
);

    bffa_pkg::t_step  r_step;
    bffa_pkg::t_step  n_step;
    bffa_pkg::t_uword w_word;
    logic             w_cond;

    assign w_word = bffa_pkg::ucode(r_step);

    always_comb begin
        case (w_word.cond)
            bffa_pkg::C_ALWAYS:      w_cond = 1'b1;
            bffa_pkg::C_PEND:        w_cond = i_flags.pend;
            bffa_pkg::C_GO:          w_cond = i_flags.go;
            bffa_pkg::C_OP_FREE:     w_cond = i_flags.stat.op_free;
            bffa_pkg::C_IDX_BAD:     w_cond = i_flags.stat.idx_bad;
            bffa_pkg::C_RANGE_EMPTY: w_cond = i_flags.stat.range_empty;
            bffa_pkg::C_CLR_LAST:    w_cond = i_flags.stat.clr_last;
            bffa_pkg::C_SCAN_DONE:   w_cond = i_flags.stat.scan_done;
            bffa_pkg::C_HIT:         w_cond = i_flags.stat.hit;
            bffa_pkg::C_CHK_LAST:    w_cond = i_flags.stat.chk_last;
            bffa_pkg::C_OUT_ROOM:    w_cond = i_flags.stat.out_room;
            default:                 w_cond = 1'b0;
        endcase
        n_step = w_cond ? w_word.jmp_t : w_word.jmp_f;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= bffa_pkg::S_CLR;
        end else begin
            r_step <= n_step;
        end
    end

    assign o_ctrl.dop  = w_word.dop;
    assign o_ctrl.fire = w_cond;

endmodule

FILE: design/bffa_dp.sv
`timescale 1ns / 1ps
// Datapath: bitmap RAM, word pointer, mask and search logic, counters, result register.
// Depends on bffa_pkg and bffa_ram; driven by the control word of bffa_seq.
module bffa_dp #(
    parameter int unsigned MAX_ENTRIES = bffa_pkg::DEF_MAX_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  bffa_pkg::t_ctrl               i_ctrl,
    input  logic [bffa_pkg::FIRST_W-1:0]  i_first,
    input  logic [bffa_pkg::TOTAL_W-1:0]  i_eff,
    input  logic [bffa_pkg::TOTAL_W-1:0]  i_size,
    input  logic                          i_operation,
    input  logic [bffa_pkg::IDX_W-1:0]    i_entry_index,
    input  logic                          i_out_stall,
    output bffa_pkg::t_dp_stat            o_stat,
    output logic                          o_out_valid,
    output logic [bffa_pkg::STAT_W-1:0]   o_status,
    output logic [bffa_pkg::IDX_W-1:0]    o_granted_index,
    output logic [bffa_pkg::CNT_W-1:0]    o_free_count
);

    localparam int unsigned WW    = bffa_pkg::WORD_W;
    localparam int unsigned ROWS  = (MAX_ENTRIES + WW - 1) / WW;
    localparam int unsigned AW    = (ROWS > 1) ? $clog2(ROWS) : 1;
    localparam int unsigned DEPTH = 1 << AW;
    localparam int unsigned XW    = AW + bffa_pkg::WORD_SH;

    logic [AW-1:0]                 r_ptr;
    logic [AW-1:0]                 r_chk;
    logic                          r_op;
    logic [bffa_pkg::IDX_W-1:0]    r_idx;
    logic [bffa_pkg::CNT_W-1:0]    r_count;
    logic [bffa_pkg::CNT_W-1:0]    r_acc;
    logic                          r_hit;
    bffa_pkg::t_status             r_status;
    logic [bffa_pkg::IDX_W-1:0]    r_granted;
    logic                          r_out_valid;
    logic [bffa_pkg::STAT_W-1:0]   r_o_status;
    logic [bffa_pkg::IDX_W-1:0]    r_o_granted;
    logic [bffa_pkg::CNT_W-1:0]    r_o_free;

    logic [WW-1:0]                 w_rdata;
    logic                          w_we;
    logic [AW-1:0]                 w_waddr;
    logic [WW-1:0]                 w_wdata;
    logic [AW-1:0]                 w_fw;
    logic [AW-1:0]                 w_lw;
    logic [bffa_pkg::TOTAL_W-1:0]  w_last;
    logic [WW-1:0]                 w_mask;
    logic [WW-1:0]                 w_free_bits;
    logic [WW-1:0]                 w_low1;
    logic                          w_hit_now;
    logic [bffa_pkg::WORD_SH-1:0]  w_pos;
    logic [bffa_pkg::POP_W-1:0]    w_pop;
    logic [XW-1:0]                 w_hit_idx;
    logic [AW-1:0]                 w_idx_word;
    logic [bffa_pkg::WORD_SH-1:0]  w_idx_bit;
    logic                          w_idx_set;
    logic                          w_emit;
    logic                          w_out_room;
    logic [bffa_pkg::CNT_W-1:0]    w_free_cnt;

    bffa_ram #(
        .WIDTH (WW),
        .DEPTH (DEPTH)
    ) u_map (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (r_ptr),
        .o_rdata (w_rdata)
    );

    assign w_last     = i_eff - bffa_pkg::TOTAL_W'(1);
    assign w_fw       = AW'(i_first >> bffa_pkg::WORD_SH);
    assign w_lw       = AW'(w_last >> bffa_pkg::WORD_SH);
    assign w_idx_word = AW'(r_idx >> bffa_pkg::WORD_SH);
    assign w_idx_bit  = r_idx[bffa_pkg::WORD_SH-1:0];
    assign w_idx_set  = w_rdata[w_idx_bit];

    // Range mask of the word under check: clip below first usable and above the last entry.
    always_comb begin
        logic [WW-1:0] lo;
        logic [WW-1:0] hi;
        lo = (r_chk == w_fw) ? ({WW{1'b1}} << i_first[bffa_pkg::WORD_SH-1:0]) : {WW{1'b1}};
        hi = (r_chk == w_lw) ? ({WW{1'b1}} >> (~w_last[bffa_pkg::WORD_SH-1:0]))
                             : {WW{1'b1}};
        w_mask = lo & hi;
    end

    assign w_free_bits = ~w_rdata & w_mask;
    assign w_low1      = w_free_bits & (~w_free_bits + WW'(1));
    assign w_hit_now   = |w_free_bits;

    // Encode the isolated lowest clear bit.
    always_comb begin
        w_pos = '0;
        for (int b = 0; b < WW; b++) begin
            if (w_low1[b]) begin
                w_pos = w_pos | bffa_pkg::WORD_SH'(b);
            end
        end
    end

    always_comb begin
        logic [WW-1:0] used;
        used  = w_rdata & w_mask;
        w_pop = '0;
        for (int b = 0; b < WW; b++) begin
            w_pop = w_pop + bffa_pkg::POP_W'(used[b]);
        end
    end

    assign w_hit_idx = {r_chk, w_pos};

    always_comb begin
        w_we    = 1'b0;
        w_waddr = r_ptr;
        w_wdata = '0;
        case (i_ctrl.dop)
            bffa_pkg::D_CLR: begin
                w_we = 1'b1;
            end
            bffa_pkg::D_FR_WRITE: begin
                w_we    = w_idx_set;
                w_wdata = w_rdata & ~(WW'(1) << w_idx_bit);
            end
            bffa_pkg::D_SCAN: begin
                w_we    = w_hit_now;
                w_waddr = r_chk;
                w_wdata = w_rdata | w_low1;
            end
            default: begin
                w_we = 1'b0;
            end
        endcase
    end

    // Control state: word pointer and the in-use count.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_count <= '0;
        end else begin
            case (i_ctrl.dop)
                bffa_pkg::D_CLR:       r_ptr <= r_ptr + AW'(1);
                bffa_pkg::D_LOAD_IDX:  r_ptr <= w_idx_word;
                bffa_pkg::D_AL_INIT:   r_ptr <= w_fw;
                bffa_pkg::D_RC_INIT:   r_ptr <= w_fw;
                bffa_pkg::D_ADV:       r_ptr <= r_ptr + AW'(1);
                bffa_pkg::D_RC_ACC:    r_ptr <= r_ptr + AW'(1);
                bffa_pkg::D_SCAN: begin
                    r_ptr <= r_ptr + AW'(1);
                    if (w_hit_now) begin
                        r_count <= r_count + bffa_pkg::CNT_W'(1);
                    end
                end
                bffa_pkg::D_FR_WRITE: begin
                    if (w_idx_set) begin
                        r_count <= r_count - bffa_pkg::CNT_W'(1);
                    end
                end
                bffa_pkg::D_RC_STORE:  r_count <= r_acc;
                default:               r_ptr <= r_ptr;
            endcase
        end
    end

    // Per-item working registers.
    always_ff @(posedge i_clk) begin
        case (i_ctrl.dop)
            bffa_pkg::D_TAKE: begin
                if (i_ctrl.fire) begin
                    r_op      <= i_operation;
                    r_idx     <= i_entry_index;
                    r_status  <= bffa_pkg::ST_OK;
                    r_granted <= '0;
                    r_hit     <= 1'b0;
                end
            end
            bffa_pkg::D_SET_RANGE: r_status <= bffa_pkg::ST_RANGE;
            bffa_pkg::D_SET_FULL:  r_status <= bffa_pkg::ST_FULL;
            bffa_pkg::D_AL_INIT:   r_acc <= '0;
            bffa_pkg::D_RC_INIT:   r_acc <= '0;
            bffa_pkg::D_ADV:       r_chk <= r_ptr;
            bffa_pkg::D_RC_ACC: begin
                r_chk <= r_ptr;
                r_acc <= r_acc + bffa_pkg::CNT_W'(w_pop);
            end
            bffa_pkg::D_SCAN: begin
                r_chk <= r_ptr;
                if (w_hit_now) begin
                    r_hit     <= 1'b1;
                    r_granted <= bffa_pkg::IDX_W'(w_hit_idx);
                end
            end
            default: r_hit <= r_hit;
        endcase
    end

    assign w_free_cnt = (i_size > r_count) ? (i_size - r_count) : '0;
    assign w_out_room = ~r_out_valid | ~i_out_stall;
    assign w_emit     = (i_ctrl.dop == bffa_pkg::D_EMIT) && i_ctrl.fire;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_o_status  <= r_status;
            r_o_granted <= r_granted;
            r_o_free    <= w_free_cnt;
        end
    end

    assign o_stat.op_free     = (r_op == bffa_pkg::OP_FREE);
    assign o_stat.idx_bad     = (bffa_pkg::TOTAL_W'(r_idx) >= i_eff) || (r_idx < i_first);
    assign o_stat.range_empty = (i_eff <= bffa_pkg::TOTAL_W'(i_first));
    assign o_stat.clr_last    = (r_ptr == {AW{1'b1}});
    assign o_stat.scan_done   = w_hit_now || (r_chk == w_lw);
    assign o_stat.hit         = r_hit;
    assign o_stat.chk_last    = (r_chk == w_lw);
    assign o_stat.out_room    = w_out_room;

    assign o_out_valid     = r_out_valid;
    assign o_status        = r_o_status;
    assign o_granted_index = r_o_granted;
    assign o_free_count    = r_o_free;

endmodule

FILE: design/bitmap_first_fit_allocator_unit.sv
`timescale 1ns / 1ps
// Top level of the first-fit bitmap allocator: register port, handshakes, sequencer and datapath.
// Depends on bffa_pkg, bffa_seq, bffa_dp (and through it bffa_ram).
//
// Usage
//   Input channel (i_in_valid / o_in_stall) carries one request beat: i_operation selects
//   allocate (lowest clear entry from first_usable up to total_entries) or free of
//   i_entry_index. Output channel (o_out_valid / i_out_stall) returns one result beat per
//   request: status, granted index and the free count of the usable range afterwards.
//   The APB-style port holds first_usable (0x0) and total_entries (0x4); a write makes the
//   block recount the used entries of the new range before it takes the next request.
// Operation
//   The bitmap sits in a RAM of 32-bit words, read one word a cycle by a microcoded sequencer.
//   Free: the word of the index is read and, if its bit is set, written back with it cleared;
//   an index outside the range is rejected. Allocate scans the words of the range from the
//   first usable one (up to 32 for 1024 entries) until a clear entry is hit, and reports
//   full on an empty range or no hit. After a register write the range is recounted word by word.
// Reset
//   i_rst_n is synchronous. After reset the sequencer sweeps the RAM to zero, one word a
//   cycle (all MAX_ENTRIES/32 words, rounded up to a power of two; 32 by default), with
//   o_in_stall high. Register writes are taken during the sweep.
// Back-pressure
//   The result register holds a finished beat while i_out_stall is high; the next request
//   is still taken and worked on, and only its own result beat waits for the slot to clear.
module bitmap_first_fit_allocator_unit #(
    parameter int unsigned MAX_ENTRIES = bffa_pkg::DEF_MAX_ENTRIES
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    // Request channel
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic                          i_operation,
    input  logic [bffa_pkg::IDX_W-1:0]    i_entry_index,
    // Result channel
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [bffa_pkg::STAT_W-1:0]   o_status,
    output logic [bffa_pkg::IDX_W-1:0]    o_granted_index,
    output logic [bffa_pkg::CNT_W-1:0]    o_free_count,
    // Register port
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [bffa_pkg::APB_AW-1:0]   paddr,
    input  logic [bffa_pkg::APB_DW-1:0]   pwdata,
    output logic [bffa_pkg::APB_DW-1:0]   prdata,
    output logic                          pready
);

    logic [bffa_pkg::FIRST_W-1:0] r_first;
    logic [bffa_pkg::TOTAL_W-1:0] r_total;
    logic                         r_pend;

    logic                         w_wr;
    logic                         w_reg;
    logic [bffa_pkg::TOTAL_W-1:0] w_eff;
    logic [bffa_pkg::TOTAL_W-1:0] w_size;
    logic                         w_accept;
    bffa_pkg::t_ctrl              w_ctrl;
    bffa_pkg::t_dp_stat           w_stat;
    bffa_pkg::t_flags             w_flags;

    // Register port: a write lands in the access phase; pready is tied high.
    assign pready = 1'b1;
    assign w_wr   = psel & penable & pwrite;
    assign w_reg  = paddr[bffa_pkg::REG_SEL_BIT];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_first <= bffa_pkg::FIRST_RST;
            r_total <= bffa_pkg::TOTAL_RST;
        end else if (w_wr) begin
            case (w_reg)
                bffa_pkg::REG_FIRST: r_first <= pwdata[bffa_pkg::FIRST_W-1:0];
                bffa_pkg::REG_TOTAL: r_total <= pwdata[bffa_pkg::TOTAL_W-1:0];
                default:             r_first <= r_first;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            bffa_pkg::REG_FIRST: prdata = bffa_pkg::APB_DW'(r_first);
            bffa_pkg::REG_TOTAL: prdata = bffa_pkg::APB_DW'(r_total);
            default:             prdata = '0;
        endcase
    end

    // A write owes a recount; a write landing as the recount starts keeps it owed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pend <= 1'b0;
        end else if (w_wr) begin
            r_pend <= 1'b1;
        end else if (w_ctrl.dop == bffa_pkg::D_RC_INIT) begin
            r_pend <= 1'b0;
        end
    end

    // Clip the total to the bitmap capacity, and size the usable range.
    assign w_eff  = (32'(r_total) > 32'(MAX_ENTRIES)) ? bffa_pkg::TOTAL_W'(MAX_ENTRIES) : r_total;
    assign w_size = (w_eff > bffa_pkg::TOTAL_W'(r_first))
                  ? (w_eff - bffa_pkg::TOTAL_W'(r_first)) : '0;

    // Take a request beat only in the dispatch step and with no recount owed.
    assign o_in_stall = !((w_ctrl.dop == bffa_pkg::D_TAKE) && !r_pend);
    assign w_accept   = i_in_valid & ~o_in_stall;

    assign w_flags.pend = r_pend;
    assign w_flags.go   = i_in_valid & ~r_pend;
    assign w_flags.stat = w_stat;

    bffa_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_flags (w_flags),
        .o_ctrl  (w_ctrl)
    );

    bffa_dp #(
        .MAX_ENTRIES (MAX_ENTRIES)
    ) u_dp (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_ctrl          (w_ctrl),
        .i_first         (r_first),
        .i_eff           (w_eff),
        .i_size          (w_size),
        .i_operation     (i_operation),
        .i_entry_index   (i_entry_index),
        .i_out_stall     (i_out_stall),
        .o_stat          (w_stat),
        .o_out_valid     (o_out_valid),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_free_count    (o_free_count)
    );

    // A request is never taken while a recount is still owed.
    a_no_take_on_pend: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |-> !r_pend)
        else $error("request taken with recount owed");

    // A full report means the usable range has no free entry left.
    a_full_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_status == bffa_pkg::ST_FULL)) |-> (o_free_count == '0))
        else $error("full reported with free entries");

    // The free count never exceeds the size of the usable range.
    a_free_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_free_count <= w_size))
        else $error("free count above range size");

endmodule

FILE: test/bitmap_first_fit_allocator_unit_tb.sv
`timescale 1ns / 1ps
// Self-checking testbench of bitmap_first_fit_allocator_unit: directed table, then random phases.
// Depends on bffa_pkg and the design files; a built-in model predicts each beat the table does not type.
module bitmap_first_fit_allocator_unit_tb;

    localparam int unsigned CAP_ENTRIES    = bffa_pkg::DEF_MAX_ENTRIES;
    localparam int unsigned LONG_HOLD      = 150;   // receiver hold-off that fills the block
    localparam int unsigned TAIL_CYCLES    = 64;    // covers the longest allocate scan plus dispatch
    localparam int unsigned WATCHDOG_LIMIT = 2000;  // cycles with no beat on either channel
    localparam int unsigned RAND_PHASES    = 10;
    localparam int unsigned PHASE_ITEMS    = 100;
    localparam int unsigned PRINT_CAP      = 100;

    // Register byte addresses: register i sits at 4*i.
    localparam logic [bffa_pkg::APB_AW-1:0] FIRST_ADDR = 3'h0;
    localparam logic [bffa_pkg::APB_AW-1:0] TOTAL_ADDR = 3'h4;

    typedef struct packed {
        bffa_pkg::t_status           status;
        logic [bffa_pkg::IDX_W-1:0]  granted;
        logic [bffa_pkg::CNT_W-1:0]  free_cnt;
    } alloc_reply_t;

    typedef enum logic [1:0] {
        ROW_REQ,
        ROW_FIRST,
        ROW_TOTAL
    } row_kind_t;

    typedef struct {
        row_kind_t    kind;
        logic         op;
        int unsigned  arg;      // entry index of a request, or the register value
        bit           typed;    // reply below is known by hand
        alloc_reply_t reply;
    } stim_row_t;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    logic i_operation;
    logic [bffa_pkg::IDX_W-1:0] i_entry_index;
    logic o_out_valid;
    logic i_out_stall;
    logic [bffa_pkg::STAT_W-1:0] o_status;
    logic [bffa_pkg::IDX_W-1:0]  o_granted_index;
    logic [bffa_pkg::CNT_W-1:0]  o_free_count;
    logic psel;
    logic penable;
    logic pwrite;
    logic [bffa_pkg::APB_AW-1:0] paddr;
    logic [bffa_pkg::APB_DW-1:0] pwdata;
    logic [bffa_pkg::APB_DW-1:0] prdata;
    logic pready;

    // Allocator model state, kept in step with every accepted request beat.
    bit   [CAP_ENTRIES-1:0]        taken_bits;
    int unsigned                   taken_count;
    logic [bffa_pkg::FIRST_W-1:0]  cfg_first;
    logic [bffa_pkg::TOTAL_W-1:0]  cfg_total;

    alloc_reply_t      replies_due[$];
    logic [9:0]        live_entries[$];   // entries handed out and not yet freed
    stim_row_t         directed_rows[$];

    bit          gaps_off;        // phase without idle cycles on either side
    bit          long_hold_req;   // ask the receiver for one long hold-off
    int unsigned err_count;
    int unsigned quiet_cycles;
    int unsigned n_alloc, n_free, n_reg_writes, n_full, n_range;

    bitmap_first_fit_allocator_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_operation     (i_operation),
        .i_entry_index   (i_entry_index),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_status        (o_status),
        .o_granted_index (o_granted_index),
        .o_free_count    (o_free_count),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // ---------------------------------------------------------------------------------
    // Allocator model
    // ---------------------------------------------------------------------------------

    // A total above capacity behaves as the capacity.
    function automatic int unsigned entry_limit();
        return (cfg_total > CAP_ENTRIES) ? CAP_ENTRIES : int'(cfg_total);
    endfunction

    // Recount the taken entries of the usable range after a register change; bits
    // outside the range stay as they are.
    function automatic void recount_taken();
        int unsigned e;
        taken_count = 0;
        for (e = cfg_first; e < entry_limit(); e++)
            if (taken_bits[e])
                taken_count++;
    endfunction

    // Work out the reply to one request beat and advance the model.
    function automatic alloc_reply_t allocator_reply(input logic op,
                                                     input logic [bffa_pkg::IDX_W-1:0] idx);
        alloc_reply_t r;
        int unsigned  lim;
        int unsigned  span;
        int unsigned  e;
        lim       = entry_limit();
        r.status  = bffa_pkg::ST_OK;
        r.granted = '0;
        if (op == bffa_pkg::OP_ALLOC) begin
            // First fit: lowest clear entry from first usable up to the limit.
            r.status = bffa_pkg::ST_FULL;
            for (e = cfg_first; e < lim && r.status == bffa_pkg::ST_FULL; e++) begin
                if (!taken_bits[e]) begin
                    taken_bits[e] = 1'b1;
                    taken_count++;
                    r.granted = e[9:0];
                    r.status  = bffa_pkg::ST_OK;
                end
            end
        end else if (idx >= lim || idx < cfg_first) begin
            // Reserved entries and entries past the total are rejected alike.
            r.status = bffa_pkg::ST_RANGE;
        end else if (taken_bits[idx]) begin
            // Freeing a taken entry clears it; one that is already free changes nothing.
            taken_bits[idx] = 1'b0;
            taken_count--;
        end
        span       = (lim > cfg_first) ? lim - cfg_first : 0;
        r.free_cnt = (span > taken_count) ? 11'(span - taken_count) : '0;
        return r;
    endfunction

    // ---------------------------------------------------------------------------------
    // Checking
    // ---------------------------------------------------------------------------------

    task automatic report_mismatch(input string what, input int unsigned got,
                                   input int unsigned want);
        if (err_count < PRINT_CAP)
            $display("[%0t] MISMATCH %s: got %0d, want %0d", $time, what, got, want);
        err_count++;
    endtask

    // Compare each accepted result beat with the oldest reply due.
    always @(posedge i_clk) begin : reply_check
        alloc_reply_t want;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (replies_due.size() == 0) begin
                report_mismatch("result beat with no request outstanding", o_status, 0);
            end else begin
                want = replies_due.pop_front();
                if (o_status !== want.status)
                    report_mismatch("status", o_status, want.status);
                if (o_granted_index !== want.granted)
                    report_mismatch("granted index", o_granted_index, want.granted);
                if (o_free_count !== want.free_cnt)
                    report_mismatch("free count", o_free_count, want.free_cnt);
            end
            if (o_status == bffa_pkg::ST_FULL)
                n_full++;
            if (o_status == bffa_pkg::ST_RANGE)
                n_range++;
        end
    end

    // Abort when neither channel moves a beat for too long.
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("Timeout: no beat for %0d cycles", WATCHDOG_LIMIT);
            $display("bitmap_first_fit_allocator_unit_tb failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------------------------
    // Result side: draw a hold-off per beat, honour the one long hold when asked
    // ---------------------------------------------------------------------------------
    initial begin : result_sink
        int unsigned hold;
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                hold = LONG_HOLD;
            end else begin
                hold = gaps_off ? 0 : $urandom_range(0, 8);
            end
            if (hold > 0) begin
                i_out_stall <= 1'b1;
                repeat (hold) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // ---------------------------------------------------------------------------------
    // Register port
    // ---------------------------------------------------------------------------------

    // A setup phase and an access phase, then an idle phase so that psel never drops
    // and rises in the same step.
    task automatic apb_cycle(input logic wr, input logic [bffa_pkg::APB_AW-1:0] addr,
                             input logic [31:0] wdata, output logic [31:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= addr;
        pwdata  <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        rdata = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge i_clk);
    endtask

    // Write a register, mirror it in the model, and read it back.
    task automatic set_register(input logic sel, input logic [31:0] wdata);
        logic [31:0] back;
        logic [31:0] want;
        apb_cycle(1'b1, (sel == bffa_pkg::REG_TOTAL) ? TOTAL_ADDR : FIRST_ADDR, wdata, back);
        if (sel == bffa_pkg::REG_TOTAL) begin
            cfg_total = wdata[bffa_pkg::TOTAL_W-1:0];
            want      = 32'(cfg_total);
        end else begin
            cfg_first = wdata[bffa_pkg::FIRST_W-1:0];
            want      = 32'(cfg_first);
        end
        recount_taken();
        n_reg_writes++;
        apb_cycle(1'b0, (sel == bffa_pkg::REG_TOTAL) ? TOTAL_ADDR : FIRST_ADDR, '0, back);
        if (back !== want)
            report_mismatch("register read-back", back, want);
    endtask

    // ---------------------------------------------------------------------------------
    // Request side
    // ---------------------------------------------------------------------------------

    // Offer one request beat after a drawn gap; predict its reply on acceptance.
    // Valid stays high after the beat, so back-to-back beats never toggle it.
    task automatic send_request(input logic op, input logic [bffa_pkg::IDX_W-1:0] idx,
                                input bit typed, input alloc_reply_t typed_reply);
        alloc_reply_t pred;
        int unsigned  gap;
        gap = gaps_off ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_operation   <= op;
        i_entry_index <= idx;
        do @(posedge i_clk); while (o_in_stall);
        pred = allocator_reply(op, idx);
        replies_due.push_back(typed ? typed_reply : pred);
        if (op == bffa_pkg::OP_ALLOC) begin
            n_alloc++;
            if (pred.status == bffa_pkg::ST_OK)
                live_entries.push_back(pred.granted);
        end else begin
            n_free++;
        end
    endtask

    // Drop valid and hold until every reply due has come back.
    task automatic drain_replies();
        i_in_valid <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge i_clk);
    endtask

    function automatic stim_row_t stim_row(input row_kind_t kind, input logic op,
                                           input int unsigned arg, input bit typed,
                                           input bffa_pkg::t_status st,
                                           input int unsigned gr, input int unsigned fc);
        stim_row_t row;
        row.kind           = kind;
        row.op             = op;
        row.arg            = arg;
        row.typed          = typed;
        row.reply.status   = st;
        row.reply.granted  = gr[9:0];
        row.reply.free_cnt = fc[10:0];
        return row;
    endfunction

    // Directed table. Typed replies where they follow at a glance; the rest go
    // through the model.
    task automatic fill_directed_rows();
        // Reset settings: first usable 10, total 1024, empty map.
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 1023, 1,
                                         bffa_pkg::ST_OK, 10, 1013));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 0, 1,
                                         bffa_pkg::ST_OK, 11, 1012));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 10, 1,
                                         bffa_pkg::ST_OK, 0, 1013));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 0, 1,
                                         bffa_pkg::ST_OK, 10, 1012));
        // Free just below first usable, and of entry zero: reserved.
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 9, 1,
                                         bffa_pkg::ST_RANGE, 0, 1012));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 0, 1,
                                         bffa_pkg::ST_RANGE, 0, 1012));
        // Free of the top entry, which is already free: ok, no change.
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 1023, 1,
                                         bffa_pkg::ST_OK, 0, 1012));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 11, 1,
                                         bffa_pkg::ST_OK, 0, 1013));
        // Four-entry range at the top of the map: fill it, then run out.
        directed_rows.push_back(stim_row(ROW_FIRST, 0, 1020, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 0, 1,
                                         bffa_pkg::ST_OK, 1020, 3));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 1023, 1,
                                         bffa_pkg::ST_OK, 1021, 2));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 0, 1,
                                         bffa_pkg::ST_OK, 1022, 1));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 1023, 1,
                                         bffa_pkg::ST_OK, 1023, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 0, 1,
                                         bffa_pkg::ST_FULL, 0, 0));
        // No reserved entries, sixteen usable; free at the total is out of range.
        directed_rows.push_back(stim_row(ROW_FIRST, 0, 0, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_TOTAL, 0, 16, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 1023, 0,
                                         bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 16, 0,
                                         bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 15, 0,
                                         bffa_pkg::ST_OK, 0, 0));
        // Total of zero: nothing valid.
        directed_rows.push_back(stim_row(ROW_TOTAL, 0, 0, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 0, 1,
                                         bffa_pkg::ST_FULL, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 0, 1,
                                         bffa_pkg::ST_RANGE, 0, 0));
        // First usable equal to the total: empty range.
        directed_rows.push_back(stim_row(ROW_FIRST, 0, 5, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_TOTAL, 0, 5, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 0, 1,
                                         bffa_pkg::ST_FULL, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 5, 1,
                                         bffa_pkg::ST_RANGE, 0, 0));
        // Total above capacity acts as capacity; the top entry is still taken.
        directed_rows.push_back(stim_row(ROW_FIRST, 0, 1023, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_TOTAL, 0, 2047, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 0, 1,
                                         bffa_pkg::ST_FULL, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_FREE, 1023, 1,
                                         bffa_pkg::ST_OK, 0, 1));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 1023, 1,
                                         bffa_pkg::ST_OK, 1023, 0));
        // Total of one below first usable: empty range again.
        directed_rows.push_back(stim_row(ROW_FIRST, 0, 10, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_TOTAL, 0, 1, 0, bffa_pkg::ST_OK, 0, 0));
        directed_rows.push_back(stim_row(ROW_REQ, bffa_pkg::OP_ALLOC, 0, 1,
                                         bffa_pkg::ST_FULL, 0, 0));
    endtask

    // ---------------------------------------------------------------------------------
    // Main sequence
    // ---------------------------------------------------------------------------------
    initial begin : stimulus
        int unsigned phase;
        int unsigned n;
        int unsigned sel;
        int unsigned k;
        int unsigned lim;
        int unsigned first_val;
        int unsigned total_val;
        logic        op;
        logic [9:0]  idx;

        // Drive every input to a known value and hold reset.
        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_operation   <= bffa_pkg::OP_ALLOC;
        i_entry_index <= '0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        taken_bits    = '0;
        taken_count   = 0;
        cfg_first     = bffa_pkg::FIRST_RST;
        cfg_total     = bffa_pkg::TOTAL_RST;
        gaps_off      = 1'b0;
        long_hold_req = 1'b0;
        fill_directed_rows();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table; register rows wait for the block to go idle.
        foreach (directed_rows[r]) begin
            if (directed_rows[r].kind == ROW_REQ) begin
                send_request(directed_rows[r].op, directed_rows[r].arg[9:0],
                             directed_rows[r].typed, directed_rows[r].reply);
            end else begin
                drain_replies();
                set_register((directed_rows[r].kind == ROW_TOTAL) ? bffa_pkg::REG_TOTAL
                                                                   : bffa_pkg::REG_FIRST,
                             directed_rows[r].arg);
            end
        end
        drain_replies();

        // Random phases, each under its own range setting.
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            case (phase)
                0: begin first_val = 0;    total_val = 1024; end
                1: begin first_val = 10;   total_val = 1024; end
                2: begin first_val = 1000; total_val = 1024; end
                3: begin first_val = 0;    total_val = 1;    end
                4: begin first_val = 1023; total_val = 2047; end
                5: begin
                    first_val = $urandom_range(0, 1000);
                    total_val = first_val + $urandom_range(1, 32);
                end
                6: begin
                    first_val = $urandom_range(0, 1023);
                    total_val = $urandom_range(0, 2047);
                end
                7: begin
                    first_val = $urandom_range(0, 40);
                    total_val = $urandom_range(1, 64);
                end
                8: begin first_val = 0;    total_val = 16;   end
                default: begin first_val = 10; total_val = 1024; end
            endcase
            // Junk in the upper data bits must be dropped by the registers.
            set_register(bffa_pkg::REG_FIRST, ($urandom << bffa_pkg::FIRST_W) | first_val);
            set_register(bffa_pkg::REG_TOTAL, ($urandom << bffa_pkg::TOTAL_W) | total_val);
            gaps_off = (phase == 2 || phase == 6);
            // Hold the result side off long enough for the block to stall its input.
            if (phase == 1)
                long_hold_req = 1'b1;

            for (n = 0; n < PHASE_ITEMS; n++) begin
                // Pause the sender once until the block has answered everything.
                if (phase == 4 && n == PHASE_ITEMS / 2)
                    drain_replies();
                lim = entry_limit();
                sel = $urandom_range(0, 99);
                idx = $urandom_range(0, 1023);
                if (sel < 50) begin
                    op = bffa_pkg::OP_ALLOC;
                end else if (sel < 80 && live_entries.size() > 0) begin
                    // Return an entry that was handed out earlier.
                    op  = bffa_pkg::OP_FREE;
                    k   = $urandom_range(0, live_entries.size() - 1);
                    idx = live_entries[k];
                    live_entries.delete(k);
                end else if (sel < 92 && lim > cfg_first) begin
                    op  = bffa_pkg::OP_FREE;
                    idx = $urandom_range(cfg_first, lim - 1);
                end else begin
                    op = bffa_pkg::OP_FREE;
                end
                send_request(op, idx, 1'b0, '0);
            end
            drain_replies();
        end

        // Let a stray beat show up before the verdict.
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (replies_due.size() != 0)
            report_mismatch("replies never returned", replies_due.size(), 0);

        $display("Covered %0d requests (%0d allocate, %0d free) and %0d register writes;",
                 n_alloc + n_free, n_alloc, n_free, n_reg_writes);
        $display("seen %0d no-free-entry and %0d out-of-range replies, %0d mismatches",
                 n_full, n_range, err_count);
        if (err_count == 0)
            $display("bitmap_first_fit_allocator_unit_tb passed");
        else
            $display("bitmap_first_fit_allocator_unit_tb failed");
        $finish;
    end

endmodule

FILE: filelist.f
design/bffa_pkg.sv
design/bffa_ram.sv
design/bffa_seq.sv
design/bffa_dp.sv
design/bitmap_first_fit_allocator_unit.sv
test/bitmap_first_fit_allocator_unit_tb.sv
